// ===== design/symbolic_port_id_mapper_unit_defines.svh =====
// assertion macros used by the port id mapper top level
`ifndef SYMBOLIC_PORT_ID_MAPPER_UNIT_DEFINES_SVH
`define SYMBOLIC_PORT_ID_MAPPER_UNIT_DEFINES_SVH

// same-cycle implication
`define SPIM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spim same-cycle check failed");

// next-cycle implication
`define SPIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("spim next-cycle check failed");

`endif

// ===== design/spim_pkg.sv =====
// shared types and constants for the port id mapper
package spim_pkg;

	localparam logic [1:0] STATUS_MAPPED = 2'd0;
	localparam logic [1:0] STATUS_PASS   = 2'd1;
	localparam logic [1:0] STATUS_FAIL   = 2'd2;

	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;

	localparam logic [7:0] SUBPORT_MAX = 8'd15;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
		logic [7:0] rollup_subport;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [16:0] port_number;
	} result_t;

	typedef struct packed {
		logic go;
		logic ends;
	} step_ctl_t;

endpackage

// ===== design/symbolic_port_id_mapper_unit.sv =====
// top level of the symbolic port id mapper
//
//   channel   direction  payload              transfer when
//   item      in         spim_pkg::item_t     item_valid && !item_stall
//   result    out        spim_pkg::result_t   result_valid && !result_stall
//
// one item per cycle unless a name-ending item waits; its result loads as it leaves stage s1
// one register stage before and one after the combinational parse logic
// a name ending item waits in the input stage while the result register is full and stalled
// reset clears the parse state and both valid flags
`include "symbolic_port_id_mapper_unit_defines.svh"

module symbolic_port_id_mapper_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  spim_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output spim_pkg::result_t  result
);

	logic                valid_s1;
	logic                ends_s1;
	logic                out_free;
	spim_pkg::item_t     item_s1;
	spim_pkg::result_t   res;
	spim_pkg::step_ctl_t ctl;
	logic                res_load;
	logic                res_taken;
	logic                item_taken;
	logic                res_unmapped;
	logic                port_clear;

	assign ctl.ends = ends_s1;
	assign ctl.go   = valid_s1 && (!ends_s1 || out_free);

	assign res_load     = ctl.go && ctl.ends;
	assign res_taken    = result_valid && !result_stall;
	assign item_taken   = item_valid && !item_stall;
	assign res_unmapped = result_valid && (result.status != spim_pkg::STATUS_MAPPED);
	assign port_clear   = (result.port_number == 17'd0);

	spim_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.go         (ctl.go),
		.valid_s1   (valid_s1),
		.ends_s1    (ends_s1),
		.item_s1    (item_s1)
	);

	spim_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.item_s1 (item_s1),
		.res     (res)
	);

	spim_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (res_load),
		.res          (res),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`SPIM_ASSERT_NOW(a_port_zero_unless_mapped, clk, arst_n, res_unmapped, port_clear)
	`SPIM_ASSERT_NOW(a_no_result_overwrite, clk, arst_n, res_load, !result_valid || !result_stall)
	`SPIM_ASSERT_NEXT(a_result_drains, clk, arst_n, res_taken && !res_load, !result_valid)
	`SPIM_ASSERT_NEXT(a_item_lands, clk, arst_n, item_taken, valid_s1)

endmodule

// ===== design/spim_in_stage.sv =====
// input register stage holding one character item
module spim_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  spim_pkg::item_t item,
	input  logic           go,
	output logic           valid_s1,
	output logic           ends_s1,
	output spim_pkg::item_t item_s1
);

	logic load;

	assign item_stall = valid_s1 && !go;
	assign load       = item_valid && !item_stall;
	assign ends_s1    = (item_s1.char_code == spim_pkg::CHAR_NUL) || item_s1.last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== design/spim_parse.sv =====
// name parser state and end-of-name port mapping
module spim_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  spim_pkg::step_ctl_t ctl,
	input  spim_pkg::item_t    item_s1,
	output spim_pkg::result_t  res
);

	typedef enum logic [2:0] {
		PH_EMPTY  = 3'd0,
		PH_SYM_X  = 3'd1,
		PH_SYM_XY = 3'd2,
		PH_SYM_N  = 3'd3,
		PH_SYM_P  = 3'd4,
		PH_NUM_D  = 3'd5,
		PH_NUM_P  = 3'd6,
		PH_PASS   = 3'd7
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [2:0]  pos_q, n_pos;
	logic [4:0]  first_q, n_first;
	logic [5:0]  second_q, n_second;
	logic [3:0]  base_q, n_base;
	logic        roll_q, n_roll;
	logic [15:0] num_q, n_num;

	logic [7:0]  c;
	logic [7:0]  sub;
	logic        is_letter, is_digit, is_plus, is_lower;
	logic [3:0]  digit;
	logic [7:0]  upper;
	logic [7:0]  b10;
	logic [15:0] num10;
	logic [8:0]  bsum;
	logic        sym, rollup;

	assign c         = item_s1.char_code;
	assign sub       = item_s1.rollup_subport;
	assign is_lower  = (c >= 8'h61) && (c <= 8'h7A);
	assign is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || is_lower;
	assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
	assign is_plus   = (c == spim_pkg::CHAR_PLUS);
	assign digit     = c[3:0];
	assign upper     = is_lower ? (c - 8'h20) : c;
	assign b10       = {1'b0, base_q, 3'b000} + {3'b000, base_q, 1'b0} + {4'b0000, digit};
	assign num10     = {num_q[12:0], 3'b000} + {num_q[14:0], 1'b0} + {12'h000, digit};

	always_comb begin
		n_phase  = phase_q;
		n_pos    = pos_q;
		n_first  = first_q;
		n_second = second_q;
		n_base   = base_q;
		n_roll   = roll_q;
		n_num    = num_q;
		if (c != spim_pkg::CHAR_NUL) begin
			case (phase_q)
				PH_EMPTY: begin
					if (is_letter) begin
						n_first = upper[4:0];
						n_phase = PH_SYM_X;
					end else if (is_digit) begin
						n_num   = {12'h000, digit};
						n_phase = PH_NUM_D;
					end else if (is_plus) begin
						n_phase = PH_NUM_P;
					end else begin
						n_phase = PH_PASS;
					end
				end
				PH_SYM_X: begin
					if (is_letter || is_digit) begin
						n_second = upper[5:0];
						n_phase  = PH_SYM_XY;
					end else begin
						n_phase = PH_PASS;
					end
				end
				PH_SYM_XY: begin
					if (is_digit) begin
						n_base  = digit;
						n_phase = PH_SYM_N;
					end else if (is_plus) begin
						n_roll  = 1'b1;
						n_phase = PH_SYM_P;
					end else begin
						n_phase = PH_PASS;
					end
				end
				PH_SYM_N: begin
					if (is_digit && (pos_q == 3'd3)) begin
						if (b10 > spim_pkg::SUBPORT_MAX) begin
							n_phase = PH_PASS;
						end else begin
							n_base = b10[3:0];
						end
					end else if (is_plus) begin
						n_roll  = 1'b1;
						n_phase = PH_SYM_P;
					end else begin
						n_phase = PH_PASS;
					end
				end
				PH_NUM_D: begin
					if (is_digit) begin
						n_num = num10;
					end else if (is_plus) begin
						n_phase = PH_NUM_P;
					end else begin
						n_phase = PH_PASS;
					end
				end
				default: begin
					n_phase = PH_PASS;
				end
			endcase
			if (pos_q != 3'd7) begin
				n_pos = pos_q + 3'd1;
			end
		end
	end

	// result for a name ending on this transfer
	assign sym    = (n_phase == PH_SYM_XY) || (n_phase == PH_SYM_N) || (n_phase == PH_SYM_P);
	assign rollup = n_roll || (n_phase == PH_SYM_XY);
	assign bsum   = {5'b00000, n_base} + {1'b0, sub};

	always_comb begin
		res.status      = spim_pkg::STATUS_PASS;
		res.port_number = '0;
		if (sym) begin
			if (((sub != 8'd0) && !rollup) || (bsum > {1'b0, spim_pkg::SUBPORT_MAX})) begin
				res.status = spim_pkg::STATUS_FAIL;
			end else begin
				res.status      = spim_pkg::STATUS_MAPPED;
				res.port_number = {1'b0, (bsum > 9'd7) ? 2'b10 : 2'b01,
					n_first, n_second, bsum[2:0]};
			end
		end else if (n_phase == PH_NUM_P) begin
			if (sub > spim_pkg::SUBPORT_MAX) begin
				res.status = spim_pkg::STATUS_FAIL;
			end else begin
				res.status      = spim_pkg::STATUS_MAPPED;
				res.port_number = {1'b0, n_num} + {9'h000, sub};
			end
		end else if (sub != 8'd0) begin
			res.status = spim_pkg::STATUS_FAIL;
		end
	end

	// state clears once a name ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_EMPTY;
			pos_q    <= 3'd0;
			first_q  <= 5'd0;
			second_q <= 6'd0;
			base_q   <= 4'd0;
			roll_q   <= 1'b0;
			num_q    <= 16'd0;
		end else if (ctl.go) begin
			if (ctl.ends) begin
				phase_q  <= PH_EMPTY;
				pos_q    <= 3'd0;
				first_q  <= 5'd0;
				second_q <= 6'd0;
				base_q   <= 4'd0;
				roll_q   <= 1'b0;
				num_q    <= 16'd0;
			end else begin
				phase_q  <= n_phase;
				pos_q    <= n_pos;
				first_q  <= n_first;
				second_q <= n_second;
				base_q   <= n_base;
				roll_q   <= n_roll;
				num_q    <= n_num;
			end
		end
	end

endmodule

// ===== design/spim_out_stage.sv =====
// result register on the output channel
module spim_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  spim_pkg::result_t  res,
	output logic               out_free,
	output logic               result_valid,
	input  logic               result_stall,
	output spim_pkg::result_t  result
);

	logic              valid_q;
	spim_pkg::result_t result_q;

	assign out_free     = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res;
		end
	end

endmodule
